/* sv/rcg_pkg.sv */
// Package with the shared widths, codes and sideband types of the texel coordinate generator.
`default_nettype none

package rcg_pkg;

    // Field widths of the channels.
    localparam int ROW_W    = 11;
    localparam int LH_W     = 16;
    localparam int TEX_W    = 9;
    localparam int FX_W     = 24;
    localparam int KOFF_W   = 12;
    localparam int CADDR_W  = 3;
    localparam int CDATA_W  = 24;

    // Fixed point format and texture size.
    localparam int FRAC_BITS = 16;
    localparam int TEX_LOG   = 9;

    // Signed pixel divisor, wide enough for 2*row - height + 2*offset.
    localparam int DIV_W  = ROW_W + 4;
    // First divider: height scaled to fixed point, or the wall row scaled to the texture.
    localparam int NUMA_W = ROW_W + FRAC_BITS;
    localparam int DENA_W = LH_W;
    // Signed difference of the current distance and the eye distance.
    localparam int T_W    = NUMA_W + 2;
    // Second divider: magnitude of that difference scaled to fixed point.
    localparam int NUMB_W = T_W - 1 + FRAC_BITS;
    localparam int DENB_W = FX_W;
    localparam int DEN2_W = FX_W + 1;
    // Saturated weight.
    localparam int W_W    = 32;

    localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;

    typedef enum logic [1:0] {
        REGION_CEIL  = 2'd0,
        REGION_WALL  = 2'd1,
        REGION_FLOOR = 2'd2
    } region_t;

    typedef enum logic [CADDR_W-1:0] {
        REG_SCREEN_HEIGHT = 3'd0,
        REG_PLAYER_X      = 3'd1,
        REG_PLAYER_Y      = 3'd2,
        REG_PLAYER_DIST   = 3'd3,
        REG_VIEW_OFFSET   = 3'd4
    } cfg_addr_t;

    typedef struct packed {
        logic [ROW_W-1:0]  screen_height;
        logic [FX_W-1:0]   player_x;
        logic [FX_W-1:0]   player_y;
        logic [FX_W-1:0]   player_dist;
        logic [KOFF_W-1:0] view_offset;
    } cfg_t;

    // Sideband that rides along the first divider.
    typedef struct packed {
        region_t           region;
        logic              fault;
        logic [TEX_W-1:0]  wall_u;
        logic              cd_neg;
        logic [DEN2_W-1:0] den2;
        logic [FX_W-1:0]   floor_x;
        logic [FX_W-1:0]   floor_y;
    } sba_t;

    // Sideband that rides along the second divider.
    typedef struct packed {
        region_t          region;
        logic             fault;
        logic [TEX_W-1:0] wall_u;
        logic [TEX_W-1:0] wall_v;
        logic             w_neg;
        logic [FX_W-1:0]  floor_x;
        logic [FX_W-1:0]  floor_y;
    } sbb_t;

endpackage

`default_nettype wire

/* sv/rcg_if.sv */
// Channel interfaces: pixel items in, texel results out, configuration writes.
`default_nettype none

interface rcg_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [rcg_pkg::ROW_W-1:0] pixel_row;
    logic [rcg_pkg::ROW_W-1:0] draw_start;
    logic [rcg_pkg::ROW_W-1:0] draw_end;
    logic [rcg_pkg::LH_W-1:0]  line_height;
    logic [rcg_pkg::TEX_W-1:0] wall_tex_x;
    logic [rcg_pkg::FX_W-1:0]  floor_x;
    logic [rcg_pkg::FX_W-1:0]  floor_y;
    logic [rcg_pkg::FX_W-1:0]  wall_dist;

    modport source (
        output valid, pixel_row, draw_start, draw_end, line_height, wall_tex_x,
               floor_x, floor_y, wall_dist,
        input  ready
    );
    modport sink (
        input  valid, pixel_row, draw_start, draw_end, line_height, wall_tex_x,
               floor_x, floor_y, wall_dist,
        output ready
    );
endinterface

interface rcg_texel_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                region;
    logic [rcg_pkg::TEX_W-1:0] tex_u;
    logic [rcg_pkg::TEX_W-1:0] tex_v;
    logic                      div_fault;

    modport source (
        output valid, region, tex_u, tex_v, div_fault,
        input  ready
    );
    modport sink (
        input  valid, region, tex_u, tex_v, div_fault,
        output ready
    );
endinterface

interface rcg_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rcg_pkg::CADDR_W-1:0] addr;
    logic [rcg_pkg::CDATA_W-1:0] data;

    modport source (
        output valid, addr, data,
        input  ready
    );
    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface

`default_nettype wire

/* sv/raycast_texel_coordinate_gen_unit.sv */
// Top level of the raycast texel coordinate generator.
//
// Usage: each transfer on the pixel channel carries one screen row of a raycast
// column together with that column's draw span, line height, wall texture
// column, floor hit point and wall distance. Each pixel yields exactly one
// transfer on the texel channel with the region (ceiling, wall, floor), the
// texel coordinates and a fault flag for a zero divisor, in input order.
// Registers (screen height, player position, eye distance, view offset) are
// written through the configuration channel, which is always ready; write them
// only while no pixel is in flight.
// The path from pixel transfer to result valid has one input stage,
// 27 stages of the first divider, two stages between the dividers, 44 stages of
// the second divider, weight and multiply stages, and the output register.
// Throughput is one pixel per cycle; the bit-per-stage dividers set the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// pixel ready drops; nothing is lost or repeated. Reset clears all valid bits
// and loads the register reset values (screen height 480, all others zero).
`default_nettype none

module raycast_texel_coordinate_gen_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rcg_pixel_if.sink   pixel,
    rcg_texel_if.source texel,
    rcg_cfg_if.sink     cfg
);

    logic                        en;
    rcg_pkg::cfg_t               regs;

    logic                        fr_valid;
    logic [rcg_pkg::NUMA_W-1:0]  fr_num;
    logic [rcg_pkg::DENA_W-1:0]  fr_den;
    rcg_pkg::sba_t               fr_sb;

    logic                        da_valid;
    logic [rcg_pkg::NUMA_W-1:0]  da_quo;
    logic [$bits(rcg_pkg::sba_t)-1:0] da_sb_vec;
    rcg_pkg::sba_t               da_sb;

    logic                        wt_valid;
    logic [rcg_pkg::NUMB_W-1:0]  wt_num;
    logic [rcg_pkg::DENB_W-1:0]  wt_den;
    rcg_pkg::sbb_t               wt_sb;

    logic                        db_valid;
    logic [rcg_pkg::NUMB_W-1:0]  db_quo;
    logic [$bits(rcg_pkg::sbb_t)-1:0] db_sb_vec;
    rcg_pkg::sbb_t               db_sb;

    rcg_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    rcg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .pixel     (pixel),
        .regs      (regs),
        .out_valid (fr_valid),
        .out_num   (fr_num),
        .out_den   (fr_den),
        .out_sb    (fr_sb)
    );

    rcg_pipe_div #(
        .NUM_W (rcg_pkg::NUMA_W),
        .DEN_W (rcg_pkg::DENA_W),
        .SB_W  ($bits(rcg_pkg::sba_t))
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .in_sb     (fr_sb),
        .out_valid (da_valid),
        .out_quo   (da_quo),
        .out_sb    (da_sb_vec)
    );

    assign da_sb = rcg_pkg::sba_t'(da_sb_vec);

    rcg_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .regs      (regs),
        .in_valid  (da_valid),
        .in_quo    (da_quo),
        .in_sb     (da_sb),
        .out_valid (wt_valid),
        .out_num   (wt_num),
        .out_den   (wt_den),
        .out_sb    (wt_sb)
    );

    rcg_pipe_div #(
        .NUM_W (rcg_pkg::NUMB_W),
        .DEN_W (rcg_pkg::DENB_W),
        .SB_W  ($bits(rcg_pkg::sbb_t))
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (wt_valid),
        .in_num    (wt_num),
        .in_den    (wt_den),
        .in_sb     (wt_sb),
        .out_valid (db_valid),
        .out_quo   (db_quo),
        .out_sb    (db_sb_vec)
    );

    assign db_sb = rcg_pkg::sbb_t'(db_sb_vec);

    rcg_texel u_texel (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .regs     (regs),
        .in_valid (db_valid),
        .in_quo   (db_quo),
        .in_sb    (db_sb),
        .texel    (texel)
    );

endmodule

`default_nettype wire

/* sv/rcg_cfg_regs.sv */
// Configuration register file written through the configuration channel.
`default_nettype none

module rcg_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rcg_cfg_if.sink      cfg,
    output rcg_pkg::cfg_t regs
);

    rcg_pkg::cfg_t regs_reg;
    rcg_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (rcg_pkg::cfg_addr_t'(cfg.addr))
                rcg_pkg::REG_SCREEN_HEIGHT:
                    regs_next.screen_height = cfg.data[rcg_pkg::ROW_W-1:0];
                rcg_pkg::REG_PLAYER_X:
                    regs_next.player_x = cfg.data[rcg_pkg::FX_W-1:0];
                rcg_pkg::REG_PLAYER_Y:
                    regs_next.player_y = cfg.data[rcg_pkg::FX_W-1:0];
                rcg_pkg::REG_PLAYER_DIST:
                    regs_next.player_dist = cfg.data[rcg_pkg::FX_W-1:0];
                rcg_pkg::REG_VIEW_OFFSET:
                    regs_next.view_offset = cfg.data[rcg_pkg::KOFF_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.screen_height <= rcg_pkg::SCREEN_HEIGHT_RST[rcg_pkg::ROW_W-1:0];
            regs_reg.player_x      <= '0;
            regs_reg.player_y      <= '0;
            regs_reg.player_dist   <= '0;
            regs_reg.view_offset   <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

/* sv/rcg_front.sv */
// Input stage: row classification, pixel divisor and operands of the first divider.
`default_nettype none

module rcg_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    rcg_pixel_if.sink                       pixel,
    input  rcg_pkg::cfg_t                   regs,
    output logic                            out_valid,
    output logic [rcg_pkg::NUMA_W-1:0]      out_num,
    output logic [rcg_pkg::DENA_W-1:0]      out_den,
    output rcg_pkg::sba_t                   out_sb
);

    localparam int DIV_W = rcg_pkg::DIV_W;

    logic                        valid_reg;
    logic [rcg_pkg::NUMA_W-1:0]  num_reg;
    logic [rcg_pkg::DENA_W-1:0]  den_reg;
    rcg_pkg::sba_t               sb_reg;

    rcg_pkg::region_t            region;
    logic signed [DIV_W-1:0]     row_s;
    logic signed [DIV_W-1:0]     h_s;
    logic signed [DIV_W-1:0]     k_s;
    logic signed [DIV_W-1:0]     pix_div;
    logic [DIV_W-1:0]            div_mag;
    logic [rcg_pkg::ROW_W-1:0]   wall_row;
    logic [rcg_pkg::DEN2_W-1:0]  den2;
    logic [rcg_pkg::NUMA_W-1:0]  num_next;
    logic [rcg_pkg::DENA_W-1:0]  den_next;
    rcg_pkg::sba_t               sb_next;

    assign pixel.ready = en;

    always_comb
    begin
        if (pixel.pixel_row < pixel.draw_start)
            region = rcg_pkg::REGION_CEIL;
        else if (pixel.pixel_row < pixel.draw_end)
            region = rcg_pkg::REGION_WALL;
        else
            region = rcg_pkg::REGION_FLOOR;

        row_s = $signed(DIV_W'(pixel.pixel_row));
        h_s   = $signed(DIV_W'(regs.screen_height));
        k_s   = $signed({{(DIV_W-rcg_pkg::KOFF_W){regs.view_offset[rcg_pkg::KOFF_W-1]}},
                         regs.view_offset});

        // A ceiling row is mirrored, which flips the sign of the whole divisor.
        if (region == rcg_pkg::REGION_CEIL)
            pix_div = h_s - (row_s <<< 1) - (k_s <<< 1);
        else
            pix_div = (row_s <<< 1) - h_s + (k_s <<< 1);

        div_mag  = pix_div[DIV_W-1] ? DIV_W'(-pix_div) : DIV_W'(pix_div);
        wall_row = pixel.pixel_row - pixel.draw_start;
        den2     = {1'b0, pixel.wall_dist} - {1'b0, regs.player_dist};

        if (region == rcg_pkg::REGION_WALL)
        begin
            num_next = rcg_pkg::NUMA_W'({wall_row, {rcg_pkg::TEX_LOG{1'b0}}});
            den_next = pixel.line_height;
        end
        else
        begin
            num_next = {regs.screen_height, {rcg_pkg::FRAC_BITS{1'b0}}};
            den_next = rcg_pkg::DENA_W'(div_mag);
        end

        sb_next.region  = region;
        sb_next.fault   = (region == rcg_pkg::REGION_WALL) ? (pixel.line_height == '0)
                                                          : (pix_div == '0 || den2 == '0);
        sb_next.wall_u  = pixel.wall_tex_x;
        sb_next.cd_neg  = pix_div[DIV_W-1];
        sb_next.den2    = den2;
        sb_next.floor_x = pixel.floor_x;
        sb_next.floor_y = pixel.floor_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
            sb_reg  <= sb_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_sb    = sb_reg;

endmodule

`default_nettype wire

/* sv/rcg_pipe_div.sv */
// Pipelined restoring divider: one quotient bit per register stage, sideband alongside.
`default_nettype none

module rcg_pipe_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 16,
    parameter int SB_W  = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] in_num,
    input  wire logic [DEN_W-1:0] in_den,
    input  wire logic [SB_W-1:0]  in_sb,
    output logic                  out_valid,
    output logic [NUM_W-1:0]      out_quo,
    output logic [SB_W-1:0]       out_sb
);

    // Stage k outputs; index 0 is the input side.
    logic             vld_st [0:NUM_W];
    logic [NUM_W-1:0] nq_st  [0:NUM_W];
    logic [SB_W-1:0]  sb_st  [0:NUM_W];
    logic [DEN_W-1:0] rem_st [0:NUM_W-1];
    logic [DEN_W-1:0] den_st [0:NUM_W-1];

    assign vld_st[0] = in_valid;
    assign nq_st[0]  = in_num;
    assign sb_st[0]  = in_sb;
    assign rem_st[0] = '0;
    assign den_st[0] = in_den;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic             vld_reg;
        logic [NUM_W-1:0] nq_reg;
        logic [SB_W-1:0]  sb_reg;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [NUM_W-1:0] nq_next;

        // The quotient bits shift in at the bottom while numerator bits leave at the top.
        assign trial   = {rem_st[k], nq_st[k][NUM_W-1]};
        assign ge      = trial >= {1'b0, den_st[k]};
        assign nq_next = {nq_st[k][NUM_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_st[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg <= nq_next;
                sb_reg <= sb_st[k];
            end
        end

        assign vld_st[k+1] = vld_reg;
        assign nq_st[k+1]  = nq_reg;
        assign sb_st[k+1]  = sb_reg;

        if (k < NUM_W - 1)
        begin : g_keep
            logic [DEN_W-1:0] rem_reg;
            logic [DEN_W-1:0] den_reg;
            logic [DEN_W-1:0] rem_next;
            logic [DEN_W:0]   diff;

            assign diff     = trial - {1'b0, den_st[k]};
            assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= rem_next;
                    den_reg <= den_st[k];
                end
            end

            assign rem_st[k+1] = rem_reg;
            assign den_st[k+1] = den_reg;
        end
    end

    assign out_valid = vld_st[NUM_W];
    assign out_quo   = nq_st[NUM_W];
    assign out_sb    = sb_st[NUM_W];

endmodule

`default_nettype wire

/* sv/rcg_weight.sv */
// Two stages between the dividers: signed distance difference, then magnitudes and sign.
`default_nettype none

module rcg_weight (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  rcg_pkg::cfg_t                    regs,
    input  wire logic                        in_valid,
    input  wire logic [rcg_pkg::NUMA_W-1:0]  in_quo,
    input  rcg_pkg::sba_t                    in_sb,
    output logic                             out_valid,
    output logic [rcg_pkg::NUMB_W-1:0]       out_num,
    output logic [rcg_pkg::DENB_W-1:0]       out_den,
    output rcg_pkg::sbb_t                    out_sb
);

    localparam int T_W = rcg_pkg::T_W;

    logic                        v1_reg;
    logic signed [T_W-1:0]       t_reg;
    logic [rcg_pkg::TEX_W-1:0]   wall_v_reg;
    rcg_pkg::sba_t               sb1_reg;

    logic                        v2_reg;
    logic [rcg_pkg::NUMB_W-1:0]  num_reg;
    logic [rcg_pkg::DENB_W-1:0]  den_reg;
    rcg_pkg::sbb_t               sb2_reg;

    logic signed [T_W-1:0]       q_ext;
    logic signed [T_W-1:0]       dp_ext;
    logic signed [T_W-1:0]       t_next;
    logic [T_W-1:0]              t_mag;
    logic signed [rcg_pkg::DEN2_W-1:0] den2_s;
    logic [rcg_pkg::DEN2_W-1:0]  den_mag;
    logic [rcg_pkg::NUMB_W-1:0]  num_next;
    rcg_pkg::sbb_t               sb_next;

    // Current distance minus eye distance, with the sign of the pixel divisor applied.
    always_comb
    begin
        q_ext  = $signed(T_W'(in_quo));
        dp_ext = $signed(T_W'(regs.player_dist));
        t_next = in_sb.cd_neg ? (-q_ext - dp_ext) : (q_ext - dp_ext);
    end

    always_comb
    begin
        den2_s   = $signed(sb1_reg.den2);
        t_mag    = t_reg[T_W-1] ? T_W'(-t_reg) : T_W'(t_reg);
        den_mag  = den2_s[rcg_pkg::DEN2_W-1] ? rcg_pkg::DEN2_W'(-den2_s)
                                             : rcg_pkg::DEN2_W'(den2_s);
        num_next = {t_mag[T_W-2:0], {rcg_pkg::FRAC_BITS{1'b0}}};

        sb_next.region  = sb1_reg.region;
        sb_next.fault   = sb1_reg.fault;
        sb_next.wall_u  = sb1_reg.wall_u;
        sb_next.wall_v  = wall_v_reg;
        sb_next.w_neg   = t_reg[T_W-1] ^ den2_s[rcg_pkg::DEN2_W-1];
        sb_next.floor_x = sb1_reg.floor_x;
        sb_next.floor_y = sb1_reg.floor_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg      <= t_next;
            wall_v_reg <= in_quo[rcg_pkg::TEX_W-1:0];
            sb1_reg    <= in_sb;
            num_reg    <= num_next;
            den_reg    <= den_mag[rcg_pkg::DENB_W-1:0];
            sb2_reg    <= sb_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_sb    = sb2_reg;

endmodule

`default_nettype wire

/* sv/rcg_texel.sv */
// Back end: weight saturation, blend multiplies, texel select and the output register.
`default_nettype none

module rcg_texel (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    output logic                             en,
    input  rcg_pkg::cfg_t                    regs,
    input  wire logic                        in_valid,
    input  wire logic [rcg_pkg::NUMB_W-1:0]  in_quo,
    input  rcg_pkg::sbb_t                    in_sb,
    rcg_texel_if.source                      texel
);

    localparam int W_W  = rcg_pkg::W_W;
    localparam int D_W  = rcg_pkg::DEN2_W;
    localparam int P_W  = W_W + D_W;
    localparam int FB   = rcg_pkg::FRAC_BITS;
    localparam int TL   = rcg_pkg::TEX_LOG;

    logic                    v1_reg;
    logic signed [W_W-1:0]   w_reg;
    logic signed [D_W-1:0]   dx_reg;
    logic signed [D_W-1:0]   dy_reg;
    rcg_pkg::sbb_t           sb1_reg;

    logic                    v2_reg;
    logic [FB-1:0]           px_reg;
    logic [FB-1:0]           py_reg;
    rcg_pkg::sbb_t           sb2_reg;

    logic                      out_valid_reg;
    logic [1:0]                region_reg;
    logic [rcg_pkg::TEX_W-1:0] u_reg;
    logic [rcg_pkg::TEX_W-1:0] v_reg;
    logic                      fault_reg;

    logic [W_W-1:0]          w_mag;
    logic signed [W_W-1:0]   w_next;
    logic signed [P_W-1:0]   prod_x;
    logic signed [P_W-1:0]   prod_y;
    logic [FB-1:0]           cx;
    logic [FB-1:0]           cy;
    logic [rcg_pkg::TEX_W-1:0] u_next;
    logic [rcg_pkg::TEX_W-1:0] v_next;

    assign en = !out_valid_reg || texel.ready;

    // Quotients beyond the signed weight range clamp to the largest magnitude.
    always_comb
    begin
        if (in_quo[rcg_pkg::NUMB_W-1:W_W-1] != '0)
            w_mag = {1'b0, {(W_W-1){1'b1}}};
        else
            w_mag = in_quo[W_W-1:0];
        w_next = in_sb.w_neg ? $signed(-w_mag) : $signed(w_mag);
    end

    assign prod_x = w_reg * dx_reg;
    assign prod_y = w_reg * dy_reg;

    // Only the fraction of the blended position matters for a wrapped texel index.
    always_comb
    begin
        cx = regs.player_x[FB-1:0] + px_reg;
        cy = regs.player_y[FB-1:0] + py_reg;
        if (sb2_reg.fault)
        begin
            u_next = '0;
            v_next = '0;
        end
        else if (sb2_reg.region == rcg_pkg::REGION_WALL)
        begin
            u_next = sb2_reg.wall_u;
            v_next = sb2_reg.wall_v;
        end
        else
        begin
            u_next = cx[FB-1:FB-TL];
            v_next = cy[FB-1:FB-TL];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg      <= w_next;
            dx_reg     <= $signed({1'b0, in_sb.floor_x} - {1'b0, regs.player_x});
            dy_reg     <= $signed({1'b0, in_sb.floor_y} - {1'b0, regs.player_y});
            sb1_reg    <= in_sb;
            px_reg     <= prod_x[2*FB-1:FB];
            py_reg     <= prod_y[2*FB-1:FB];
            sb2_reg    <= sb1_reg;
            region_reg <= sb2_reg.region;
            u_reg      <= u_next;
            v_reg      <= v_next;
            fault_reg  <= sb2_reg.fault;
        end
    end

    assign texel.valid     = out_valid_reg;
    assign texel.region    = region_reg;
    assign texel.tex_u     = u_reg;
    assign texel.tex_v     = v_reg;
    assign texel.div_fault = fault_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_raycast_texel_coordinate_gen_unit.sv */
// Testbench for the raycast texel coordinate generator: random and directed pixels.
`timescale 1ns / 100ps
`default_nettype none

module tb_raycast_texel_coordinate_gen_unit;

    localparam int ROW_W     = rcg_pkg::ROW_W;
    localparam int LH_W      = rcg_pkg::LH_W;
    localparam int TEX_W     = rcg_pkg::TEX_W;
    localparam int FX_W      = rcg_pkg::FX_W;
    localparam int KOFF_W    = rcg_pkg::KOFF_W;
    localparam int CDATA_W   = rcg_pkg::CDATA_W;
    localparam int FRAC_BITS = rcg_pkg::FRAC_BITS;

    typedef struct {
        rcg_pkg::region_t region;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             div_fault;
    } texel_t;

    typedef struct {
        logic [ROW_W-1:0] pixel_row;
        logic [ROW_W-1:0] draw_start;
        logic [ROW_W-1:0] draw_end;
        logic [LH_W-1:0]  line_height;
        logic [TEX_W-1:0] wall_tex_x;
        logic [FX_W-1:0]  floor_x;
        logic [FX_W-1:0]  floor_y;
        logic [FX_W-1:0]  wall_dist;
    } pixel_t;

    localparam int LATENCY = 77;
    localparam longint ONE_FX = 64'sd1 << FRAC_BITS;
    localparam longint W_SAT = 64'sd2147483647;

    logic clk;
    logic rst_n;

    rcg_pixel_if pixel ();
    rcg_texel_if texel ();
    rcg_cfg_if   cfg ();

    raycast_texel_coordinate_gen_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel.sink),
        .texel (texel.source),
        .cfg   (cfg.sink)
    );

    // Shadow copy of the register file.
    logic [ROW_W-1:0]  sh_height;
    logic [FX_W-1:0]   sh_px;
    logic [FX_W-1:0]   sh_py;
    logic [FX_W-1:0]   sh_pdist;
    logic [KOFF_W-1:0] sh_offset;

    texel_t texel_expected[$];
    int     error_count;
    int     texel_count;
    int     fault_count;
    int     region_seen[3];
    bit     send_no_idle;
    bit     recv_no_idle;

    initial
    begin
        clk = 1'b0;
    end
    always #6 clk = ~clk;

    // Floor division by 2^FRAC_BITS.
    function automatic longint floor_fx(longint v);
        longint q;
        q = v / ONE_FX;
        if (v < 0 && (v % ONE_FX) != 0)
            q -= 1;
        return q;
    endfunction

    function automatic logic [TEX_W-1:0] wrap_texel(longint v);
        longint r;
        r = v % 512;
        if (r < 0)
            r += 512;
        return r[TEX_W-1:0];
    endfunction

    function automatic logic [TEX_W-1:0] blend_texel(longint player, longint w, longint pt);
        longint c;
        c = player + floor_fx(w * (pt - player));
        return wrap_texel(floor_fx(c * 512));
    endfunction

    function automatic texel_t predict_texel(pixel_t p);
        texel_t t;
        longint row, ds, de, h, koff, dp, r, dv, den, cd, w;
        row = longint'(p.pixel_row);
        ds = longint'(p.draw_start);
        de = longint'(p.draw_end);
        h = longint'(sh_height);
        koff = longint'($signed(sh_offset));
        dp = longint'(sh_pdist);
        t.tex_u = '0;
        t.tex_v = '0;
        t.div_fault = 1'b0;
        if (row < ds)
            t.region = rcg_pkg::REGION_CEIL;
        else if (row < de)
            t.region = rcg_pkg::REGION_WALL;
        else
            t.region = rcg_pkg::REGION_FLOOR;
        if (t.region == rcg_pkg::REGION_WALL)
        begin
            if (p.line_height == 0)
                t.div_fault = 1'b1;
            else
            begin
                t.tex_u = p.wall_tex_x;
                t.tex_v = wrap_texel(((row - ds) * 512) / longint'(p.line_height));
            end
        end
        else
        begin
            if (t.region == rcg_pkg::REGION_CEIL)
            begin
                r = h - row;
                dv = 2 * r - h - 2 * koff;
            end
            else
            begin
                r = row;
                dv = 2 * r - h + 2 * koff;
            end
            den = longint'(p.wall_dist) - dp;
            if (dv == 0 || den == 0)
                t.div_fault = 1'b1;
            else
            begin
                cd = (h * ONE_FX) / dv;
                w = ((cd - dp) * ONE_FX) / den;
                if (w > W_SAT)
                    w = W_SAT;
                if (w < -W_SAT)
                    w = -W_SAT;
                t.tex_u = blend_texel(longint'(sh_px), w, longint'(p.floor_x));
                t.tex_v = blend_texel(longint'(sh_py), w, longint'(p.floor_y));
            end
        end
        return t;
    endfunction

    // Valid stays high between back to back transfers and drops only while idling.
    task automatic send_pixel(pixel_t p);
        while (!send_no_idle && $urandom_range(99) < 33)
        begin
            pixel.valid <= 1'b0;
            @(posedge clk);
        end
        pixel.valid       <= 1'b1;
        pixel.pixel_row   <= p.pixel_row;
        pixel.draw_start  <= p.draw_start;
        pixel.draw_end    <= p.draw_end;
        pixel.line_height <= p.line_height;
        pixel.wall_tex_x  <= p.wall_tex_x;
        pixel.floor_x     <= p.floor_x;
        pixel.floor_y     <= p.floor_y;
        pixel.wall_dist   <= p.wall_dist;
        @(posedge clk);
        while (!pixel.ready)
            @(posedge clk);
        texel_expected.push_back(predict_texel(p));
    endtask

    task automatic write_reg(rcg_pkg::cfg_addr_t addr, logic [CDATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.addr  <= addr;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (addr)
            rcg_pkg::REG_SCREEN_HEIGHT: sh_height = data[ROW_W-1:0];
            rcg_pkg::REG_PLAYER_X:      sh_px = data;
            rcg_pkg::REG_PLAYER_Y:      sh_py = data;
            rcg_pkg::REG_PLAYER_DIST:   sh_pdist = data;
            rcg_pkg::REG_VIEW_OFFSET:   sh_offset = data[KOFF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        pixel.valid <= 1'b0;
        while (texel_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic set_view(int height, int px, int py, int pdist, int offset);
        drain();
        write_reg(rcg_pkg::REG_SCREEN_HEIGHT, CDATA_W'(height));
        write_reg(rcg_pkg::REG_PLAYER_X, CDATA_W'(px));
        write_reg(rcg_pkg::REG_PLAYER_Y, CDATA_W'(py));
        write_reg(rcg_pkg::REG_PLAYER_DIST, CDATA_W'(pdist));
        write_reg(rcg_pkg::REG_VIEW_OFFSET, CDATA_W'(offset & 12'hFFF));
        cfg.valid <= 1'b0;
    endtask

    function automatic pixel_t random_pixel(int height);
        pixel_t p;
        int span;
        p.pixel_row   = ROW_W'($urandom_range(height - 1 > 0 ? height - 1 : 0));
        p.draw_start  = ROW_W'($urandom_range(height / 2));
        p.draw_end    = ROW_W'(int'(p.draw_start) + int'($urandom_range(height / 2)));
        span          = int'(p.draw_end) - int'(p.draw_start);
        p.line_height = LH_W'(span + int'($urandom_range(64)));
        p.wall_tex_x  = TEX_W'($urandom);
        p.floor_x     = FX_W'($urandom);
        p.floor_y     = FX_W'($urandom);
        p.wall_dist   = FX_W'($urandom_range(24'h0A0000, 24'h001000));
        // Some pixels use raw fields across their full ranges.
        if ($urandom_range(9) < 2)
        begin
            p.pixel_row   = ROW_W'($urandom);
            p.draw_start  = ROW_W'($urandom);
            p.draw_end    = ROW_W'($urandom);
            p.line_height = LH_W'($urandom);
            p.wall_dist   = FX_W'($urandom);
        end
        if ($urandom_range(49) == 0)
            p.line_height = '0;
        return p;
    endfunction

    task automatic test_directed;
        pixel_t p;
        p = '{pixel_row: 0, draw_start: 100, draw_end: 380, line_height: 280,
              wall_tex_x: 511, floor_x: 24'h030000, floor_y: 24'h058000,
              wall_dist: 24'h020000};
        send_pixel(p);
        p.pixel_row = 100; send_pixel(p);
        p.pixel_row = 379; send_pixel(p);
        p.pixel_row = 380; send_pixel(p);
        p.pixel_row = 479; send_pixel(p);
        p.pixel_row = 2047; send_pixel(p);
        // Divisor zero on the horizon row, for both ceiling and floor.
        p.pixel_row = 240; p.draw_start = 300; send_pixel(p);
        p.draw_start = 0; p.draw_end = 0; send_pixel(p);
        // Zero line height and zero wall distance.
        p.draw_start = 100; p.draw_end = 380; p.line_height = 0; send_pixel(p);
        p.line_height = 1; p.pixel_row = 379; send_pixel(p);
        p.wall_dist = 0; p.pixel_row = 10; send_pixel(p);
        // Start above end: no wall rows.
        p.wall_dist = 24'hFFFFFF; p.draw_start = 400; p.draw_end = 50;
        p.pixel_row = 200; send_pixel(p);
        p.pixel_row = 450; send_pixel(p);
        p = '{pixel_row: 2047, draw_start: 2047, draw_end: 2047, line_height: 16'hFFFF,
              wall_tex_x: 0, floor_x: 24'hFFFFFF, floor_y: 0, wall_dist: 1};
        send_pixel(p);
        p.draw_start = 0; p.pixel_row = 0; send_pixel(p);
    endtask

    task automatic test_extreme_views;
        pixel_t p;
        set_view(1, 24'hFFFFFF, 0, 0, 1024);
        for (int i = 0; i < 10; i++)
        begin
            p = random_pixel(2);
            send_pixel(p);
        end
        set_view(2047, 0, 24'hFFFFFF, 24'hFFFFFF, -1024);
        for (int i = 0; i < 10; i++)
        begin
            p = random_pixel(2047);
            send_pixel(p);
        end
        // Wall distance equal to eye distance faults.
        p = random_pixel(2047);
        p.draw_start = 2047; p.pixel_row = 5; p.wall_dist = 24'hFFFFFF;
        send_pixel(p);
    endtask

    task automatic test_random_views;
        pixel_t p;
        int height;
        for (int phase = 0; phase < 6; phase++)
        begin
            height = (phase == 0) ? 480 : int'($urandom_range(2047, 16));
            set_view(height, int'($urandom), int'($urandom),
                     int'($urandom_range(24'h008000)),
                     int'($urandom_range(2048)) - 1024);
            send_no_idle = (phase == 2);
            recv_no_idle = (phase == 2);
            for (int i = 0; i < 110; i++)
            begin
                p = random_pixel(height);
                send_pixel(p);
            end
            send_no_idle = 1'b0;
            recv_no_idle = 1'b0;
        end
    endtask

    // Result checker with random back pressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            texel.ready <= recv_no_idle || ($urandom_range(99) >= 33);
            if (texel.valid && texel.ready)
            begin
                texel_t e;
                if (texel_expected.size() == 0)
                begin
                    $error("texel result with no pixel pending");
                    error_count++;
                end
                else
                begin
                    e = texel_expected.pop_front();
                    texel_count++;
                    if (e.div_fault)
                        fault_count++;
                    region_seen[e.region]++;
                    if (texel.region !== e.region)
                    begin
                        $error("region: expected %0d, got %0d", e.region, texel.region);
                        error_count++;
                    end
                    if (texel.tex_u !== e.tex_u)
                    begin
                        $error("tex_u: expected %0d, got %0d", e.tex_u, texel.tex_u);
                        error_count++;
                    end
                    if (texel.tex_v !== e.tex_v)
                    begin
                        $error("tex_v: expected %0d, got %0d", e.tex_v, texel.tex_v);
                        error_count++;
                    end
                    if (texel.div_fault !== e.div_fault)
                    begin
                        $error("div_fault: expected %0d, got %0d", e.div_fault,
                               texel.div_fault);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        pixel.valid = 1'b0;
        pixel.pixel_row = '0;
        pixel.draw_start = '0;
        pixel.draw_end = '0;
        pixel.line_height = '0;
        pixel.wall_tex_x = '0;
        pixel.floor_x = '0;
        pixel.floor_y = '0;
        pixel.wall_dist = '0;
        texel.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.addr = rcg_pkg::REG_SCREEN_HEIGHT;
        cfg.data = '0;
        sh_height = ROW_W'(480);
        sh_px = '0;
        sh_py = '0;
        sh_pdist = '0;
        sh_offset = '0;
        error_count = 0;
        texel_count = 0;
        fault_count = 0;
        send_no_idle = 1'b0;
        recv_no_idle = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_extreme_views();
        test_random_views();
        drain();
        $display("Checked %0d texel results: %0d ceiling, %0d wall, %0d floor, %0d faults.",
                 texel_count, region_seen[0], region_seen[1], region_seen[2], fault_count);
        $display("Screen heights, player positions, eye distances and offsets were varied.");
        if (error_count == 0)
            $display("tb_raycast_texel_coordinate_gen_unit OK");
        else
            $display("tb_raycast_texel_coordinate_gen_unit NOT OK");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_raycast_texel_coordinate_gen_unit NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
